/* design/sdc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the CRC7 helper for the SD SPI command engine.
package sdc_pkg;

   localparam int unsigned QueueDepth = 4;

   localparam logic [31:0] TimeoutReset = 32'd16000000;
   localparam logic [7:0]  DummyByte    = 8'hFF;
   localparam logic [7:0]  IdleByte     = 8'hFF;
   localparam logic [1:0]  CmdPrefix    = 2'b01;
   localparam logic [6:0]  Crc7Poly     = 7'h09;
   localparam logic [2:0]  FrameLastBeat = 3'd6;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_RX    = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_END   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_NONE    = 2'd0,
      STATUS_FOUND   = 2'd1,
      STATUS_TIMEOUT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      JOB_FRAME   = 2'd0,
      JOB_RESP    = 2'd1,
      JOB_RELEASE = 2'd2
   } job_kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [5:0]  cmd_index;
      logic [31:0] cmd_argument;
      logic [7:0]  rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_last;
      status_type resp_status;
      logic [7:0] resp_byte;
      logic       select_active;
   } rsp_type;

   typedef struct packed {
      job_kind_type job_kind;
      logic [5:0]   cmd_index;
      logic [31:0]  cmd_argument;
      status_type   resp_status;
      logic [7:0]   resp_byte;
      logic         select_active;
   } job_type;

   // Fold one byte, MSB first, into a CRC7 (x^7 + x^3 + 1).
   function automatic logic [6:0] crc7_byte(input logic [6:0] crc_i, input logic [7:0] data_i);
      logic [6:0] crc;
      logic       fb;
      crc = crc_i;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[6] ^ data_i[i];
         crc = {crc[5:0], 1'b0} ^ (fb ? Crc7Poly : 7'd0);
      end
      return crc;
   endfunction

endpackage

/* design/sd_spi_command_engine.sv */
`timescale 1ns / 1ps
// Top level of the SD card SPI-mode command engine.
//
// Usage:
//  - Request side is a queue write port: drive req_data and raise push; the word
//    is taken at a rising edge with push high and full low. A word is a start
//    command, a received card byte, a timebase tick or an end (release select).
//  - Result side is a queue read port: while empty is low, rsp_data holds the
//    oldest result word; raise pop to take it.
//  - A start command yields seven words (dummy 0xFF, 0x40 plus index, four
//    argument bytes MSB first, CRC7 byte with end bit), one per cycle as popped.
//    Received bytes during a response wait and end commands yield one word.
//    Ticks and bytes outside a wait yield none.
//  - A request is queued as a job, then its word is registered for the reader.
//  - Throughput: one request word per cycle unless full; results drain one per
//    cycle as popped, set by the single output register of the frame sequencer.
//  - A stalled reader fills the job queue (QUEUE_DEPTH jobs); full then stops
//    the request side, ticks included. Nothing is dropped.
//  - csr_write_en/csr_write_data set the response timeout in ticks; write it
//    only while the engine is idle.
//  - Synchronous reset: select released, no wait, queue empty, timeout 16000000.
module sd_spi_command_engine #(
   parameter int unsigned QUEUE_DEPTH = sdc_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  sdc_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output sdc_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic [31:0]      csr_write_data
);

   // Job link between front end, queue and sequencer.
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   sdc_pkg::job_type q_job;
   sdc_pkg::job_type q_head;

   // Front end: classify each request and update select/wait/tick state.
   sdc_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_job          (q_job)
   );

   // Decouple the front end from a stalled result reader.
   sdc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .job_in (q_job),
      .pop    (q_pop),
      .head   (q_head),
      .full   (q_full),
      .empty  (q_empty)
   );

   // Sequencer: one result word per cycle while the reader keeps up, CRC7 built byte by byte.
   sdc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

/* design/sdc_front.sv */
`timescale 1ns / 1ps
// Front end: takes request words, tracks select and response wait, posts jobs.
module sdc_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  sdc_pkg::req_type req_data,
   input  logic            csr_write_en,
   input  logic [31:0]     csr_write_data,
   input  logic            q_full,
   output logic            q_push,
   output sdc_pkg::job_type q_job
);

   logic        waiting_ff, waiting_in;
   logic        select_ff, select_in;
   logic [31:0] elapsed_ff, elapsed_in;
   logic [31:0] timeout_ff, timeout_in;
   logic        accept;

   assign full   = q_full;
   assign accept = push && !q_full;

   always_comb begin
      waiting_in = waiting_ff;
      select_in  = select_ff;
      elapsed_in = elapsed_ff;
      timeout_in = csr_write_en ? csr_write_data : timeout_ff;
      q_push     = 1'b0;
      q_job.job_kind      = sdc_pkg::JOB_RESP;
      q_job.cmd_index     = req_data.cmd_index;
      q_job.cmd_argument  = req_data.cmd_argument;
      q_job.resp_status   = sdc_pkg::STATUS_NONE;
      q_job.resp_byte     = 8'd0;
      q_job.select_active = select_ff;
      if (accept) begin
         case (req_data.kind)
            sdc_pkg::KIND_START: begin
               q_push              = 1'b1;
               q_job.job_kind      = sdc_pkg::JOB_FRAME;
               q_job.select_active = 1'b1;
               select_in           = 1'b1;
               waiting_in          = 1'b1;
               elapsed_in          = 32'd0;
            end
            sdc_pkg::KIND_RX: begin
               if (waiting_ff) begin
                  q_push = 1'b1;
                  if (req_data.rx_byte != sdc_pkg::IdleByte) begin
                     q_job.resp_status = sdc_pkg::STATUS_FOUND;
                     q_job.resp_byte   = req_data.rx_byte;
                     waiting_in        = 1'b0;
                  end else if (elapsed_ff > timeout_ff) begin
                     q_job.resp_status = sdc_pkg::STATUS_TIMEOUT;
                     waiting_in        = 1'b0;
                  end
               end
            end
            sdc_pkg::KIND_TICK: begin
               if (waiting_ff && (elapsed_ff != '1)) begin
                  elapsed_in = elapsed_ff + 32'd1;
               end
            end
            sdc_pkg::KIND_END: begin
               q_push              = 1'b1;
               q_job.job_kind      = sdc_pkg::JOB_RELEASE;
               q_job.select_active = 1'b0;
               select_in           = 1'b0;
               waiting_in          = 1'b0;
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_ff <= 1'b0;
         select_ff  <= 1'b0;
         elapsed_ff <= 32'd0;
         timeout_ff <= sdc_pkg::TimeoutReset;
      end else begin
         waiting_ff <= waiting_in;
         select_ff  <= select_in;
         elapsed_ff <= elapsed_in;
         timeout_ff <= timeout_in;
      end
   end

   // A wait never stands without chip select driven.
   assert property (@(posedge clock) disable iff (reset) waiting_ff |-> select_ff)
      else $error("response wait without select");
   // Hold the tick count while no wait is open.
   assert property (@(posedge clock) disable iff (reset)
      (!waiting_ff && !waiting_in) |=> $stable(elapsed_ff))
      else $error("tick count moved while idle");
   // A timeout job only comes from a wait.
   assert property (@(posedge clock) disable iff (reset)
      (q_push && q_job.resp_status == sdc_pkg::STATUS_TIMEOUT) |-> waiting_ff)
      else $error("timeout without wait");

endmodule

/* design/sdc_queue.sv */
`timescale 1ns / 1ps
// Short job queue between the front end and the frame sequencer.
module sdc_queue #(
   parameter int unsigned DEPTH = sdc_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  sdc_pkg::job_type job_in,
   input  logic             pop,
   output sdc_pkg::job_type head,
   output logic             full,
   output logic             empty
);

   localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntW = $clog2(DEPTH + 1);

   sdc_pkg::job_type entry_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;

   assign full  = (count_ff == CntW'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push |-> !full)
      else $error("job pushed into full queue");
   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("job popped from empty queue");
   assert property (@(posedge clock) disable iff (reset) count_ff <= CntW'(DEPTH))
      else $error("queue count overflow");

endmodule

/* design/sdc_back.sv */
`timescale 1ns / 1ps
// Back end: expands jobs into result words, builds the frame and CRC7.
module sdc_back (
   input  logic             clock,
   input  logic             reset,
   input  sdc_pkg::job_type head,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             empty,
   input  logic             pop,
   output sdc_pkg::rsp_type rsp_data
);

   logic             out_valid_ff, out_valid_in;
   sdc_pkg::rsp_type out_ff;
   sdc_pkg::rsp_type word;
   logic [2:0]       beat_ff, beat_in;
   logic [6:0]       crc_ff, crc_in;
   logic             advance;
   logic             last_beat;
   logic [7:0]       frame_byte;

   assign empty    = !out_valid_ff;
   assign rsp_data = out_ff;
   assign advance  = !q_empty && (!out_valid_ff || pop);

   always_comb begin
      case (beat_ff)
         3'd0:    frame_byte = sdc_pkg::DummyByte;
         3'd1:    frame_byte = {sdc_pkg::CmdPrefix, head.cmd_index};
         3'd2:    frame_byte = head.cmd_argument[31:24];
         3'd3:    frame_byte = head.cmd_argument[23:16];
         3'd4:    frame_byte = head.cmd_argument[15:8];
         3'd5:    frame_byte = head.cmd_argument[7:0];
         default: frame_byte = {crc_ff, 1'b1};
      endcase
   end

   always_comb begin
      word.tx_valid      = 1'b0;
      word.tx_byte       = 8'd0;
      word.tx_last       = 1'b0;
      word.resp_status   = head.resp_status;
      word.resp_byte     = head.resp_byte;
      word.select_active = head.select_active;
      last_beat          = 1'b1;
      crc_in             = crc_ff;
      case (head.job_kind)
         sdc_pkg::JOB_FRAME: begin
            word.tx_valid    = 1'b1;
            word.tx_byte     = frame_byte;
            word.tx_last     = (beat_ff == sdc_pkg::FrameLastBeat);
            word.resp_status = sdc_pkg::STATUS_NONE;
            word.resp_byte   = 8'd0;
            last_beat        = (beat_ff == sdc_pkg::FrameLastBeat);
            if (beat_ff == 3'd0) begin
               crc_in = 7'd0;
            end else if (beat_ff != sdc_pkg::FrameLastBeat) begin
               crc_in = sdc_pkg::crc7_byte(crc_ff, frame_byte);
            end
         end
         sdc_pkg::JOB_RESP: begin
            last_beat = 1'b1;
         end
         sdc_pkg::JOB_RELEASE: begin
            word.resp_status = sdc_pkg::STATUS_NONE;
            word.resp_byte   = 8'd0;
         end
         default: begin
            last_beat = 1'b1;
         end
      endcase
   end

   assign q_pop   = advance && last_beat;
   assign beat_in = advance ? (last_beat ? 3'd0 : beat_ff + 3'd1) : beat_ff;

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= word;
         crc_ff <= crc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         beat_ff      <= 3'd0;
      end else begin
         out_valid_ff <= out_valid_in;
         beat_ff      <= beat_in;
      end
   end

   // Mid-frame the head job must stay a frame job.
   assert property (@(posedge clock) disable iff (reset)
      (beat_ff != 3'd0) |-> (!q_empty && head.job_kind == sdc_pkg::JOB_FRAME))
      else $error("frame beat without frame job");
   // The last frame byte releases the job from the queue.
   assert property (@(posedge clock) disable iff (reset)
      (advance && head.job_kind == sdc_pkg::JOB_FRAME && beat_ff == sdc_pkg::FrameLastBeat)
      |-> q_pop)
      else $error("CRC byte sent without pop");
   // A word marked last carries a frame byte.
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.tx_last) |-> out_ff.tx_valid)
      else $error("last flag on non-frame word");

endmodule
